[rtl/skt_pkg.sv]
package skt_pkg;

    localparam int CAPACITY     = 64;
    localparam int KEY_BITS     = 64;
    localparam int PAYLOAD_BITS = 32;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // fixed port field widths
    localparam int KEY_W  = 64;
    localparam int PAY_W  = 32;
    localparam int POS_W  = 6;
    localparam int SLOT_W = 7;

    typedef enum logic [1:0] {
        K_INSERT = 2'd0,
        K_LOOKUP = 2'd1,
        K_READ   = 2'd2,
        K_CLEAR  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_DONE  = 3'd0,
        ST_DUP   = 3'd1,
        ST_FULL  = 3'd2,
        ST_MISS  = 3'd3,
        ST_RANGE = 3'd4
    } t_status;

    typedef struct packed {
        logic [1:0]       kind;
        logic [KEY_W-1:0] entry_key;
        logic [PAY_W-1:0] entry_payload;
        logic [POS_W-1:0] position;
    } t_in;

    typedef struct packed {
        logic [2:0]        status;
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-1:0] count;
        logic [KEY_W-1:0]  read_key;
        logic [PAY_W-1:0]  read_payload;
    } t_out;

    typedef struct packed {
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_entry;

endpackage

[rtl/skt_store.sv]
module skt_store (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [skt_pkg::IDX_W-1:0] i_waddr,
    input  skt_pkg::t_entry          i_wdata,
    input  logic [skt_pkg::IDX_W-1:0] i_raddr,
    output skt_pkg::t_entry          o_rdata
);
    import skt_pkg::*;

    t_entry r_mem [CAPACITY];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/sorted_key_table_insert_search_core.sv]
// Sorted key table: up to CAPACITY entries kept in ascending unsigned key order.
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one command beat:
// insert, lookup, read at position, or clear. Output channel (o_out_valid /
// i_out_ready / o_out_data) returns exactly one result beat per command.
// One command is in flight at a time; o_in_ready is high only while idle.
// Steps from accept to result, with s the slot of an insert:
//   clear: straight to the result; read: one table read, then the result;
//   lookup: binary search (one table read plus one compare per probe
//           through the single read port), then the result;
//   insert: the search, then entries from s on shifted up one slot, one entry
//           moved per cycle by the read/write pipeline on the table memory.
// The result sits in an output register; a new command may be accepted while
// it waits, but the next result is held back until the receiver takes it.
// Reset (synchronous, i_rst_n low) empties the table; table memory contents
// are not cleared and are never used beyond the entry count.
module sorted_key_table_insert_search_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  skt_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output skt_pkg::t_out o_out_data
);
    import skt_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SRCH  = 7'b0000010,
        S_CMP   = 7'b0000100,
        S_RDW   = 7'b0001000,
        S_SHIFT = 7'b0010000,
        S_INS   = 7'b0100000,
        S_RESP  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [CNT_W-1:0]        r_count, n_count;
    t_kind                   r_kind, n_kind;
    logic [KEY_BITS-1:0]     r_key, n_key;
    logic [PAYLOAD_BITS-1:0] r_pay, n_pay;
    logic [POS_W-1:0]        r_pos, n_pos;
    logic [CNT_W-1:0]        r_lo, n_lo;
    logic [CNT_W-1:0]        r_hi, n_hi;
    logic [IDX_W-1:0]        r_mid, n_mid;
    logic [CNT_W-1:0]        r_slot, n_slot;
    logic [CNT_W-1:0]        r_idx, n_idx;
    logic                    r_wpend, n_wpend;
    logic [IDX_W-1:0]        r_waddr, n_waddr;
    t_out                    r_res, n_res;
    logic                    r_out_valid, n_out_valid;
    t_out                    r_out_data, n_out_data;

    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    t_entry           w_wdata;
    logic [IDX_W-1:0] w_raddr;
    t_entry           w_rdata;
    logic [CNT_W:0]   w_mid_sum;
    logic [IDX_W-1:0] w_mid;
    logic             w_hit;
    logic [CNT_W-1:0] w_srch_slot;
    logic             w_srch_done;

    skt_store u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid     = IDX_W'(w_mid_sum >> 1);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_kind      = r_kind;
        n_key       = r_key;
        n_pay       = r_pay;
        n_pos       = r_pos;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_slot      = r_slot;
        n_idx       = r_idx;
        n_wpend     = r_wpend;
        n_waddr     = r_waddr;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        w_we        = 1'b0;
        w_waddr     = r_waddr;
        w_wdata     = w_rdata;
        w_raddr     = IDX_W'(i_in_data.position);
        w_hit       = 1'b0;
        w_srch_slot = r_lo;
        w_srch_done = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_kind = t_kind'(i_in_data.kind);
                    n_key  = KEY_BITS'(i_in_data.entry_key);
                    n_pay  = PAYLOAD_BITS'(i_in_data.entry_payload);
                    n_pos  = i_in_data.position;
                    unique case (t_kind'(i_in_data.kind))
                        K_INSERT, K_LOOKUP: begin
                            n_lo    = '0;
                            n_hi    = r_count;
                            n_state = S_SRCH;
                        end
                        K_READ: begin
                            if ((POS_W + CNT_W)'(i_in_data.position) <
                                (POS_W + CNT_W)'(r_count)) begin
                                n_state = S_RDW;
                            end else begin
                                n_res   = '{status: ST_RANGE,
                                            slot: SLOT_W'(i_in_data.position),
                                            count: SLOT_W'(r_count),
                                            read_key: '0, read_payload: '0};
                                n_state = S_RESP;
                            end
                        end
                        K_CLEAR: begin
                            n_count = '0;
                            n_res   = '{status: ST_DONE, slot: '0, count: '0,
                                        read_key: '0, read_payload: '0};
                            n_state = S_RESP;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_SRCH: begin
                w_raddr = w_mid;
                if (r_lo < r_hi) begin
                    n_mid   = w_mid;
                    n_state = S_CMP;
                end else begin
                    w_srch_slot = r_lo;
                    w_srch_done = 1'b1;
                end
            end
            S_CMP: begin
                if (r_key == w_rdata.key) begin
                    w_hit       = 1'b1;
                    w_srch_slot = CNT_W'(r_mid);
                    w_srch_done = 1'b1;
                end else if (r_key < w_rdata.key) begin
                    n_hi    = CNT_W'(r_mid);
                    n_state = S_SRCH;
                end else begin
                    n_lo    = CNT_W'(r_mid) + CNT_W'(1);
                    n_state = S_SRCH;
                end
            end
            S_RDW: begin
                n_res   = '{status: ST_DONE, slot: SLOT_W'(r_pos),
                            count: SLOT_W'(r_count),
                            read_key: KEY_W'(w_rdata.key),
                            read_payload: PAY_W'(w_rdata.payload)};
                n_state = S_RESP;
            end
            S_SHIFT: begin
                // read entry idx-1 while writing the one fetched last cycle
                w_raddr = IDX_W'(r_idx - CNT_W'(1));
                if (r_wpend) begin
                    w_we    = 1'b1;
                    w_waddr = r_waddr;
                    w_wdata = w_rdata;
                end
                if (r_idx > r_slot) begin
                    n_waddr = IDX_W'(r_idx);
                    n_wpend = 1'b1;
                    n_idx   = r_idx - CNT_W'(1);
                end else begin
                    n_wpend = 1'b0;
                    n_state = S_INS;
                end
            end
            S_INS: begin
                w_we    = 1'b1;
                w_waddr = IDX_W'(r_slot);
                w_wdata = '{key: r_key, payload: r_pay};
                n_count = r_count + CNT_W'(1);
                n_res   = '{status: ST_DONE, slot: SLOT_W'(r_slot),
                            count: SLOT_W'(r_count + CNT_W'(1)),
                            read_key: '0, read_payload: '0};
                n_state = S_RESP;
            end
            S_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_data  = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // end of binary search: settle the outcome
        if (w_srch_done) begin
            n_res = '{status: ST_DONE, slot: SLOT_W'(w_srch_slot),
                      count: SLOT_W'(r_count), read_key: '0, read_payload: '0};
            n_state = S_RESP;
            if (r_kind == K_LOOKUP) begin
                if (w_hit) begin
                    n_res.read_key     = KEY_W'(w_rdata.key);
                    n_res.read_payload = PAY_W'(w_rdata.payload);
                end else begin
                    n_res.status = ST_MISS;
                end
            end else if (w_hit) begin
                n_res.status = ST_DUP;
            end else if (r_count == CNT_W'(CAPACITY)) begin
                n_res.status = ST_FULL;
            end else begin
                n_slot  = w_srch_slot;
                n_idx   = r_count;
                n_wpend = 1'b0;
                n_state = S_SHIFT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_wpend     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_wpend     <= n_wpend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_key      <= n_key;
        r_pay      <= n_pay;
        r_pos      <= n_pos;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_mid      <= n_mid;
        r_slot     <= n_slot;
        r_idx      <= n_idx;
        r_waddr    <= n_waddr;
        r_res      <= n_res;
        r_out_data <= n_out_data;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

[rtl/skt_checker.sv]
module skt_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input skt_pkg::t_in  i_in_data,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input skt_pkg::t_out o_out_data
);
    import skt_pkg::*;

    // one command at a time: busy right after an accepted beat
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready stayed high after accept");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.count <= SLOT_W'(CAPACITY))
        else $error("count above capacity");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_FULL
            |-> o_out_data.count == SLOT_W'(CAPACITY))
        else $error("full status with room left");

    a_no_data_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == ST_DUP || o_out_data.status == ST_FULL ||
                        o_out_data.status == ST_MISS || o_out_data.status == ST_RANGE)
            |-> o_out_data.read_key == '0 && o_out_data.read_payload == '0)
        else $error("read data on failed command");

endmodule

bind sorted_key_table_insert_search_core skt_checker u_skt_checker (.*);

[verif/table_result_checker.sv]
`timescale 1ns / 100ps

module table_result_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  skt_pkg::t_in  i_in_data,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  skt_pkg::t_out i_out_data,
    output int            o_errors,
    output int            o_pending
);
    import skt_pkg::*;

    // shadow copy of the table
    logic [KEY_BITS-1:0]     key_tab [CAPACITY];
    logic [PAYLOAD_BITS-1:0] pay_tab [CAPACITY];
    int unsigned             n_used;

    t_out pending_results[$];

    initial begin
        o_errors  = 0;
        o_pending = 0;
        n_used    = 0;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t checker: %s mismatch, got %h want %h", $time, what, got, want);
        o_errors++;
    endtask

    // binary search over the entries in use; on a miss, at is the insertion point
    function automatic bit find_slot(input logic [KEY_BITS-1:0] k, output int unsigned at);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 0;
        hi = n_used;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (k == key_tab[mid]) begin
                at = mid;
                return 1'b1;
            end
            if (k < key_tab[mid]) hi = mid;
            else lo = mid + 1;
        end
        at = lo;
        return 1'b0;
    endfunction

    function automatic t_out predict_result(input t_in cmd);
        t_out        r;
        int unsigned at;
        bit          hit;
        int          i;
        r  = '0;
        at = 0;
        case (t_kind'(cmd.kind))
            K_INSERT: begin
                hit    = find_slot(cmd.entry_key, at);
                r.slot = SLOT_W'(at);
                if (hit) begin
                    r.status = ST_DUP;
                end else if (n_used >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = n_used; i > int'(at); i--) begin
                        key_tab[i] = key_tab[i-1];
                        pay_tab[i] = pay_tab[i-1];
                    end
                    key_tab[at] = cmd.entry_key;
                    pay_tab[at] = cmd.entry_payload;
                    n_used++;
                    r.status = ST_DONE;
                end
            end
            K_LOOKUP: begin
                hit    = find_slot(cmd.entry_key, at);
                r.slot = SLOT_W'(at);
                if (hit) begin
                    r.status       = ST_DONE;
                    r.read_key     = key_tab[at];
                    r.read_payload = pay_tab[at];
                end else begin
                    r.status = ST_MISS;
                end
            end
            K_READ: begin
                r.slot = SLOT_W'(cmd.position);
                if (cmd.position < n_used) begin
                    r.status       = ST_DONE;
                    r.read_key     = key_tab[cmd.position];
                    r.read_payload = pay_tab[cmd.position];
                end else begin
                    r.status = ST_RANGE;
                end
            end
            default: begin
                n_used   = 0;
                r.status = ST_DONE;
            end
        endcase
        r.count = SLOT_W'(n_used);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            n_used = 0;
            pending_results.delete();
        end else begin
            // results first: a command taken at this edge cannot answer at it
            if (i_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result beat", 64'(i_out_data.status), 64'd0);
                end else begin
                    want = pending_results.pop_front();
                    if (i_out_data.status !== want.status)
                        report_mismatch("status", 64'(i_out_data.status), 64'(want.status));
                    if (i_out_data.slot !== want.slot)
                        report_mismatch("slot", 64'(i_out_data.slot), 64'(want.slot));
                    if (i_out_data.count !== want.count)
                        report_mismatch("count", 64'(i_out_data.count), 64'(want.count));
                    if (i_out_data.read_key !== want.read_key)
                        report_mismatch("read_key", i_out_data.read_key, want.read_key);
                    if (i_out_data.read_payload !== want.read_payload)
                        report_mismatch("read_payload", 64'(i_out_data.read_payload),
                                        64'(want.read_payload));
                end
            end
            if (i_in_valid && i_in_ready)
                pending_results.push_back(predict_result(i_in_data));
        end
        o_pending = pending_results.size();
    end

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import skt_pkg::*;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    t_in  in_data;
    logic out_valid;
    logic out_ready;
    t_out out_data;

    int errors;
    int pending;
    int n_sent;
    int long_hold;
    bit quiet;

    sorted_key_table_insert_search_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    table_result_checker table_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial clk = 1'b0;
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("testbench: errors");
        $finish;
    end

    function automatic logic [63:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    // called right after a rising edge; returns right after the edge that took the beat
    task automatic send_cmd(input t_kind kind, input logic [63:0] key,
                            input logic [31:0] pay, input logic [5:0] pos);
        t_in c;
        int  gap;
        bit  taken;
        c.kind          = kind;
        c.entry_key     = key;
        c.entry_payload = pay;
        c.position      = pos;
        gap = quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= c;
        do begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end while (!taken);
        n_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
    endtask

    // clear, insert until the table overflows, with duplicates, then reads and lookups
    task automatic fill_table(input bit descending);
        logic [63:0] made[$];
        logic [63:0] k;
        int          i;
        send_cmd(K_CLEAR, rand_key(), $urandom, 6'($urandom));
        k = rand_key();
        while (made.size() < 67) begin
            if (made.size() > 0 && $urandom_range(0, 5) == 0) begin
                send_cmd(K_INSERT, made[$urandom_range(0, made.size() - 1)], $urandom,
                         6'($urandom));
            end else begin
                // descending keys land at slot 0: longest shift
                k = descending ? k - 64'($urandom_range(1, 1000)) : rand_key();
                made.push_back(k);
                send_cmd(K_INSERT, k, $urandom, 6'($urandom));
            end
        end
        for (i = 0; i < 12; i++)
            send_cmd(K_READ, rand_key(), $urandom, 6'($urandom_range(0, 63)));
        for (i = 0; i < 12; i++)
            send_cmd(K_LOOKUP, $urandom_range(0, 1) ? made[$urandom_range(0, made.size() - 1)]
                                                     : rand_key(), $urandom, 6'($urandom));
    endtask

    // operations on a small key set so hits and duplicates are common
    task automatic mixed_burst();
        logic [63:0] pool [12];
        logic [63:0] base;
        int          i;
        int          n;
        int          r;
        base = rand_key();
        for (i = 0; i < 12; i++) begin
            case ($urandom_range(0, 3))
                0: pool[i] = rand_key();
                1: pool[i] = base + 64'(i);
                2: pool[i] = $urandom_range(0, 1) ? '0 : '1;
                default: pool[i] = base ^ (64'd1 << $urandom_range(0, 63));
            endcase
        end
        if ($urandom_range(0, 2) == 0)
            send_cmd(K_CLEAR, rand_key(), $urandom, 6'($urandom));
        n = $urandom_range(8, 24);
        for (i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 40)
                send_cmd(K_INSERT, pool[$urandom_range(0, 11)], $urandom, 6'($urandom));
            else if (r < 70)
                send_cmd(K_LOOKUP, $urandom_range(0, 4) ? pool[$urandom_range(0, 11)]
                                                         : rand_key(), $urandom, 6'($urandom));
            else if (r < 95)
                send_cmd(K_READ, rand_key(), $urandom,
                         $urandom_range(0, 1) ? 6'($urandom_range(0, 15)) : 6'($urandom));
            else
                send_cmd(K_CLEAR, rand_key(), $urandom, 6'($urandom));
        end
    endtask

    task automatic noise_burst();
        int i;
        int n;
        n = $urandom_range(4, 12);
        for (i = 0; i < n; i++)
            send_cmd(t_kind'($urandom_range(0, 3)), rand_key(), $urandom,
                     6'($urandom_range(0, 63)));
    endtask

    // result side: random stall per beat, or one long hold when asked
    initial begin
        int n;
        bit taken;
        out_ready <= 1'b0;
        @(posedge clk);
        forever begin
            if (long_hold > 0) begin
                n         = long_hold;
                long_hold = 0;
            end else begin
                n = quiet ? 0 : $urandom_range(0, 11);
            end
            if (n > 0) begin
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            out_ready <= 1'b1;
            do begin
                @(negedge clk);
                taken = out_valid;
                @(posedge clk);
            end while (!taken);
        end
    end

    initial begin
        int round;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        n_sent    = 0;
        long_hold = 0;
        quiet     = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // empty table, extremes of the key range, duplicates, misses, range errors
        send_cmd(K_READ,   '0, '0, 6'd0);
        send_cmd(K_LOOKUP, 64'd5, '0, '0);
        send_cmd(K_INSERT, '0, '0, '0);
        send_cmd(K_INSERT, '1, '1, '1);
        send_cmd(K_INSERT, 64'h8000_0000_0000_0000, 32'h8000_0000, 6'd0);
        send_cmd(K_INSERT, 64'h7fff_ffff_ffff_ffff, 32'h7fff_ffff, 6'd0);
        send_cmd(K_INSERT, '0, 32'h1234_5678, 6'd0);
        send_cmd(K_INSERT, '1, 32'h0, 6'd0);
        send_cmd(K_LOOKUP, '1, '0, '0);
        send_cmd(K_LOOKUP, '0, '0, '0);
        send_cmd(K_LOOKUP, 64'h8000_0000_0000_0001, '0, '0);
        send_cmd(K_READ,   '0, '0, 6'd0);
        send_cmd(K_READ,   '0, '0, 6'd3);
        send_cmd(K_READ,   '0, '0, 6'd4);
        send_cmd(K_READ,   '1, '1, 6'd63);
        send_cmd(K_CLEAR,  '1, '1, '1);
        send_cmd(K_READ,   '0, '0, 6'd0);
        send_cmd(K_LOOKUP, '0, '0, '0);
        send_cmd(K_INSERT, 64'd1, 32'ha5a5_a5a5, 6'd0);
        send_cmd(K_READ,   '0, '0, 6'd0);
        send_cmd(K_CLEAR,  '0, '0, '0);

        round = 0;
        while (n_sent < 385) begin
            quiet = ($urandom_range(0, 3) == 0);
            if (round == 2) begin
                // hold results back while commands keep coming
                quiet     = 1'b1;
                long_hold = 300;
                mixed_burst();
            end else if (round == 0 || $urandom_range(0, 7) == 0) begin
                fill_table(round == 0 ? 1'b1 : 1'($urandom_range(0, 1)));
            end else if ($urandom_range(0, 3) == 0) begin
                noise_burst();
            end else begin
                mixed_burst();
            end
            if (round == 1 || $urandom_range(0, 3) == 0)
                wait_drained();
            round++;
        end

        quiet = 1'b0;
        wait_drained();
        repeat (100) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
